// File: design/hrms_pkg.sv
// shared types and constants for the homing reciprocating motor sequencer
`default_nettype none

package hrms_pkg;

   localparam int ADC_W  = 12;
   localparam int ENC_W  = 16;
   localparam int AVG_W  = 28;
   localparam int DUTY_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_FRACTION  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PERIOD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_LEVEL    = 3'd5;

   // register reset values
   localparam logic [15:0] RST_FILTER_GAIN    = 16'd131;
   localparam logic [11:0] RST_PEAK_THRESHOLD = 12'd1117;
   localparam logic [15:0] RST_SETTLE_TICKS   = 16'd5000;
   localparam logic [7:0]  RST_TURN_FRACTION  = 8'd90;
   localparam logic [15:0] RST_PWM_PERIOD     = 16'd1000;
   localparam logic [8:0]  RST_DRIVE_LEVEL    = 9'd128;

   // sequence phases
   localparam logic [1:0] PH_SEEK_LEFT  = 2'd0;
   localparam logic [1:0] PH_SEEK_RIGHT = 2'd1;
   localparam logic [1:0] PH_OPERATE    = 2'd2;
   localparam logic [1:0] PH_UNUSED     = 2'd3;

   typedef struct packed {
      logic [15:0]       filter_gain;
      logic [11:0]       peak_threshold;
      logic [15:0]       settle_ticks;
      logic [7:0]        turn_fraction;
      logic [DUTY_W-1:0] duty;
   } cfg_type;

   // pipeline stage control: load takes a word in, drain hands the held word on
   typedef struct packed {
      logic load;
      logic drain;
   } stage_ctl_type;

endpackage

`default_nettype wire

// File: design/hrms_csr.sv
// configuration registers and the precomputed drive duty
`default_nettype none

module hrms_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hrms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hrms_pkg::CSR_DATA_W-1:0] csr_data,
   output hrms_pkg::cfg_type                   cfg
);
   import hrms_pkg::*;

   logic [15:0] gain_ff, gain_in;
   logic [11:0] thr_ff, thr_in;
   logic [15:0] settle_ff, settle_in;
   logic [7:0]  turn_ff, turn_in;
   logic [15:0] period_ff, period_in;
   logic [8:0]  level_ff, level_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [24:0] duty_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_in   = gain_ff;
      thr_in    = thr_ff;
      settle_in = settle_ff;
      turn_in   = turn_ff;
      period_in = period_ff;
      level_in  = level_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FILTER_GAIN:    gain_in   = csr_data;
            REG_PEAK_THRESHOLD: thr_in    = csr_data[11:0];
            REG_SETTLE_TICKS:   settle_in = csr_data;
            REG_TURN_FRACTION:  turn_in   = csr_data[7:0];
            REG_PWM_PERIOD:     period_in = csr_data;
            REG_DRIVE_LEVEL:    level_in  = csr_data[8:0];
            default: ;
         endcase
      end
   end

   // period * level >> 8, saturated; registered from the stored period and level
   assign duty_prod = period_ff * level_ff;
   assign duty_in   = duty_prod[24] ? {DUTY_W{1'b1}} : duty_prod[23:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= RST_FILTER_GAIN;
         thr_ff    <= RST_PEAK_THRESHOLD;
         settle_ff <= RST_SETTLE_TICKS;
         turn_ff   <= RST_TURN_FRACTION;
         period_ff <= RST_PWM_PERIOD;
         level_ff  <= RST_DRIVE_LEVEL;
      end else begin
         gain_ff   <= gain_in;
         thr_ff    <= thr_in;
         settle_ff <= settle_in;
         turn_ff   <= turn_in;
         period_ff <= period_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff <= duty_in;
   end

   assign cfg.filter_gain    = gain_ff;
   assign cfg.peak_threshold = thr_ff;
   assign cfg.settle_ticks   = settle_ff;
   assign cfg.turn_fraction  = turn_ff;
   assign cfg.duty           = duty_ff;

endmodule

`default_nettype wire

// File: design/hrms_filter.sv
// first-order low-pass filter stage on the current samples
`default_nettype none

module hrms_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hrms_pkg::stage_ctl_type       ctl,
   input  wire logic [hrms_pkg::ADC_W-1:0]    sample,
   input  wire logic [hrms_pkg::ENC_W-1:0]    enc,
   input  wire logic [15:0]                   gain,
   output logic                               valid,
   output logic [hrms_pkg::AVG_W-1:0]         avg,
   output logic [hrms_pkg::ENC_W-1:0]         enc_q
);
   import hrms_pkg::*;

   logic              valid_ff, valid_in;
   logic [AVG_W-1:0]  avg_ff, avg_in;
   logic [ENC_W-1:0]  enc_ff;
   logic signed [AVG_W:0]    diff;
   logic signed [AVG_W+17:0] prod;
   logic [AVG_W+1:0]         step;
   logic [AVG_W+1:0]         sum;

   // avg + floor(gain * ((sample << 16) - avg) / 2^16)
   assign diff = $signed({1'b0, sample, 16'b0}) - $signed({1'b0, avg_ff});
   assign prod = diff * $signed({1'b0, gain});
   assign step = prod[AVG_W+17:16];
   assign sum  = {2'b00, avg_ff} + step;

   assign avg_in   = ctl.load ? sum[AVG_W-1:0] : avg_ff;
   assign valid_in = ctl.load | (valid_ff & ~ctl.drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         avg_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         avg_ff   <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         enc_ff <= enc;
      end
   end

   assign valid = valid_ff;
   assign avg   = avg_ff;
   assign enc_q = enc_ff;

endmodule

`default_nettype wire

// File: design/hrms_ctrl.sv
// homing and reciprocation sequencer with the result register
`default_nettype none

module hrms_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hrms_pkg::stage_ctl_type        ctl,
   input  wire hrms_pkg::cfg_type              cfg,
   input  wire logic [hrms_pkg::AVG_W-1:0]     avg,
   input  wire logic [hrms_pkg::ENC_W-1:0]     enc,
   output logic                                valid,
   output logic [hrms_pkg::DUTY_W-1:0]         duty_a,
   output logic [hrms_pkg::DUTY_W-1:0]         duty_b,
   output logic                                current_peak,
   output logic [1:0]                          phase,
   output logic [hrms_pkg::AVG_W-1:0]          filtered_current
);
   import hrms_pkg::*;

   // sequencer state
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  prev_ff, prev_in;
   logic [15:0] dwell_ff, dwell_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] centre_ff, centre_in;
   logic        dir_ff, dir_in;

   // result register
   logic              valid_ff, valid_in;
   logic [DUTY_W-1:0] da_ff, da_in;
   logic [DUTY_W-1:0] db_ff, db_in;
   logic              peak_ff, peak_in;
   logic [AVG_W-1:0]  filt_ff;

   logic        accept;
   logic [16:0] end_sum;
   logic [16:0] end_sum_adj;
   logic signed [16:0] offset;
   logic signed [26:0] lhs;
   logic signed [24:0] rhs_prod;
   logic signed [26:0] rhs;
   logic signed [26:0] rhs_neg;
   logic        above;
   logic        below;

   assign peak_in = avg > {cfg.peak_threshold, 16'b0};

   // cross-multiply: 2*(enc-centre)/width vs turn/256
   assign offset   = $signed({enc[15], enc}) - $signed({centre_ff[15], centre_ff});
   assign lhs      = {offset[16], offset, 9'b0};
   assign rhs_prod = $signed({1'b0, cfg.turn_fraction}) * $signed(width_ff);
   assign rhs      = {{2{rhs_prod[24]}}, rhs_prod};
   assign rhs_neg  = -rhs;

   always_comb begin
      above = 1'b0;
      below = 1'b0;
      if (width_ff != 16'd0) begin
         if (width_ff[15]) begin
            above = lhs < rhs;
            below = lhs > rhs_neg;
         end else begin
            above = lhs > rhs;
            below = lhs < rhs_neg;
         end
      end
   end

   // centre rounds toward zero
   assign end_sum     = {enc[15], enc} + {left_ff[15], left_ff};
   assign end_sum_adj = end_sum + {16'b0, end_sum[16] & end_sum[0]};

   always_comb begin
      if (prev_ff != phase_ff) begin
         dwell_in = 16'd0;
      end else if (dwell_ff != 16'hFFFF) begin
         dwell_in = dwell_ff + 16'd1;
      end else begin
         dwell_in = dwell_ff;
      end
      prev_in = phase_ff;
      accept  = peak_in && (dwell_in > cfg.settle_ticks);

      phase_in  = phase_ff;
      left_in   = left_ff;
      width_in  = width_ff;
      centre_in = centre_ff;
      dir_in    = dir_ff;
      da_in     = '0;
      db_in     = '0;

      unique case (phase_ff)
         PH_SEEK_LEFT: begin
            da_in = cfg.duty;
            if (accept) begin
               left_in  = enc;
               phase_in = PH_SEEK_RIGHT;
            end
         end
         PH_SEEK_RIGHT: begin
            db_in = cfg.duty;
            if (accept) begin
               width_in  = enc - left_ff;
               centre_in = end_sum_adj[16:1];
               phase_in  = PH_OPERATE;
            end
         end
         PH_OPERATE: begin
            if (!dir_ff && above) begin
               dir_in = 1'b1;
            end else if (dir_ff && below) begin
               dir_in = 1'b0;
            end
            if (dir_in) begin
               da_in = cfg.duty;
            end else begin
               db_in = cfg.duty;
            end
         end
         default: ;
      endcase
   end

   assign valid_in = ctl.load | (valid_ff & ~ctl.drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         phase_ff  <= PH_SEEK_LEFT;
         prev_ff   <= PH_SEEK_LEFT;
         dwell_ff  <= '0;
         left_ff   <= '0;
         width_ff  <= '0;
         centre_ff <= '0;
         dir_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.load) begin
            phase_ff  <= phase_in;
            prev_ff   <= prev_in;
            dwell_ff  <= dwell_in;
            left_ff   <= left_in;
            width_ff  <= width_in;
            centre_ff <= centre_in;
            dir_ff    <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         da_ff   <= da_in;
         db_ff   <= db_in;
         peak_ff <= peak_in;
         filt_ff <= avg;
      end
   end

   assign valid            = valid_ff;
   assign duty_a           = da_ff;
   assign duty_b           = db_ff;
   assign current_peak     = peak_ff;
   assign phase            = phase_ff;
   assign filtered_current = filt_ff;

endmodule

`default_nettype wire

// File: design/homing_reciprocating_motor_sequencer.sv
// top level: input register, filter stage, sequencer stage and result register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  req     | in        | req_tvalid/req_tready  | req_tdata: sample, encoder count
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: duties, peak, phase, current
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// three register stages: input word, filter update, sequencer with result register
// one word per cycle sustained while rsp_tready holds
// the filter multiply-accumulate is the loop that sets the per-cycle path
// each stage holds its word while the next one is full, so rsp stalls back up to req
// synchronous reset empties the pipeline and returns to seek left with defaults
`default_nettype none

module homing_reciprocating_motor_sequencer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [11:0] adc_sample, [27:12] encoder_count, [31:28] zero
   input  wire logic [hrms_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [15:0] duty_a, [31:16] duty_b, [32] current_peak, [34:33] phase,
   // [62:35] filtered_current, [63] zero
   output logic [hrms_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hrms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hrms_pkg::CSR_DATA_W-1:0] csr_data
);
   import hrms_pkg::*;

   cfg_type       cfg;
   stage_ctl_type flt_ctl;
   stage_ctl_type seq_ctl;

   logic             in_valid_ff, in_valid_in;
   logic [ADC_W-1:0] in_sample_ff;
   logic [ENC_W-1:0] in_enc_ff;
   logic             req_take;

   logic             flt_valid;
   logic [AVG_W-1:0] flt_avg;
   logic [ENC_W-1:0] flt_enc;

   logic              out_valid;
   logic [DUTY_W-1:0] out_duty_a;
   logic [DUTY_W-1:0] out_duty_b;
   logic              out_peak;
   logic [1:0]        out_phase;
   logic [AVG_W-1:0]  out_filt;

   logic out_free;
   logic flt_free;
   logic in_free;

   // ready chain from the result side back to the input
   assign out_free = ~out_valid | rsp_tready;
   assign flt_free = ~flt_valid | out_free;
   assign in_free  = ~in_valid_ff | flt_free;

   assign req_tready = in_free;
   assign req_take   = req_tvalid & in_free;

   assign flt_ctl.load  = in_valid_ff & flt_free;
   assign flt_ctl.drain = flt_valid & out_free;
   assign seq_ctl.load  = flt_valid & out_free;
   assign seq_ctl.drain = out_valid & rsp_tready;

   assign in_valid_in = req_take | (in_valid_ff & ~flt_ctl.load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_tdata[ADC_W-1:0];
         in_enc_ff    <= req_tdata[ADC_W+ENC_W-1:ADC_W];
      end
   end

   hrms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hrms_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (flt_ctl),
      .sample (in_sample_ff),
      .enc    (in_enc_ff),
      .gain   (cfg.filter_gain),
      .valid  (flt_valid),
      .avg    (flt_avg),
      .enc_q  (flt_enc)
   );

   hrms_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .ctl              (seq_ctl),
      .cfg              (cfg),
      .avg              (flt_avg),
      .enc              (flt_enc),
      .valid            (out_valid),
      .duty_a           (out_duty_a),
      .duty_b           (out_duty_b),
      .current_peak     (out_peak),
      .phase            (out_phase),
      .filtered_current (out_filt)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {1'b0, out_filt, out_phase, out_peak, out_duty_b, out_duty_a};

endmodule

`default_nettype wire

// File: design/hrms_checker.sv
// port-level checks on the sequencer, bound to the top level
`default_nettype none

module hrms_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [hrms_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hrms_pkg::*;

   logic [1:0] rsp_phase;
   assign rsp_phase = rsp_tdata[34:33];

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed or dropped");

   a_one_side_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] == 16'd0) || (rsp_tdata[31:16] == 16'd0))
      else $error("both bridge sides driven at once");

   a_phase_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid || (rsp_phase >= $past(rsp_phase)))
      else $error("sequence phase went backward");

endmodule

bind homing_reciprocating_motor_sequencer hrms_checker u_hrms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
